/* sv/dps_pkg.sv */
// types and constants shared by the dynamic priority scheduler files
package dps_pkg;

	// result status codes
	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_REQUEUED = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;

	// action codes
	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_RUN = 1'b1;

	// one ready queue entry
	typedef struct packed {
		logic [7:0] run;
		logic [7:0] need;
		logic [7:0] prio;
		logic [7:0] id;
	} entry_t;

	// input item
	typedef struct packed {
		logic       action;
		logic [7:0] proc_id;
		logic [7:0] priority_req;
		logic [7:0] need_time;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] ran_id;
		logic [7:0] new_priority;
		logic [7:0] run_time;
		logic [4:0] queue_count;
	} out_item_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t ins;
	} cell_ctl_t;

endpackage

/* sv/dps_chan_if.sv */
// valid/ready channel carrying one item of a given payload type
interface dps_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* sv/dps_cell.sv */
// one cell of the sorted queue chain: holds one entry, shifts or takes the insert
module dps_cell
	import dps_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,
	input  logic      left_ge,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      ge
);

	entry_t entry_q;

	// this cell stays ahead of the inserted entry
	assign ge    = occ && (entry_q.prio >= ctl.ins.prio);
	assign entry = entry_q;

	// pop shifts the chain toward the head; insert opens a gap at the first cell behind the equal-or-higher run
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.insert && !ge) begin
			if (left_ge) begin
				entry_q <= ctl.ins;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule

/* sv/dynamic_priority_scheduler_unit.sv */
// top level of the dynamic priority scheduler: cell chain and item control
//
//  channel    role   payload
//  request    sink   action, proc_id, priority_req, need_time
//  response   source status, ran_id, new_priority, run_time, queue_count
//
// an add item and a run on an empty queue are answered from the accept state; any other run item
// pops the head out of the cell chain on accept and moves to the run state, where the head is
// aged and re-inserted unless it has finished.
// arst_n clears the entry count, the control state and the result valid;
// cell contents are not reset, a cell counts only below the entry count.
// a waiting result holds the block until it is taken or taken in the same cycle.
module dynamic_priority_scheduler_unit
	import dps_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
)(
	input logic clk,
	input logic arst_n,
	dps_chan_if.sink   request,
	dps_chan_if.source response
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {S_ACCEPT, S_RUN} state_t;

	state_t    state_q;
	logic [CW-1:0] count_q;
	entry_t    hold_q;
	out_item_t out_q;
	logic      out_valid_q;

	in_item_t  req;
	logic      out_free;
	logic      out_set;
	logic      accept;
	logic      full;
	logic      empty;
	logic [CW-1:0] cnt_plus;
	logic [CW-1:0] cnt_minus;
	logic [CW+4:0] ext_now;
	logic [CW+4:0] ext_plus;
	logic [7:0] run_inc;
	logic [7:0] prio_dec;
	logic      finish;
	entry_t    new_entry;
	entry_t    requeue_entry;
	cell_ctl_t ctl;

	entry_t    cell_entry [QUEUE_DEPTH];
	logic      cell_ge    [QUEUE_DEPTH];

	assign req = request.data;

	// handshake
	assign out_free       = !out_valid_q || response.ready;
	assign request.ready  = (state_q == S_ACCEPT) && out_free;
	assign accept         = request.valid && request.ready;
	assign response.valid = out_valid_q;
	assign response.data  = out_q;

	// a result is produced by an add, an idle run or the run state
	assign out_set = (accept && ((req.action == ACT_ADD) || empty)) ||
	                 ((state_q == S_RUN) && out_free);

	// count helpers
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign cnt_plus  = count_q + CW'(1);
	assign cnt_minus = count_q - CW'(1);
	assign ext_now   = (CW+5)'(count_q);
	assign ext_plus  = (CW+5)'(cnt_plus);

	// aging of the popped head
	assign run_inc  = (hold_q.run == 8'hFF) ? 8'hFF : hold_q.run + 8'd1;
	assign finish   = (run_inc >= hold_q.need);
	assign prio_dec = (hold_q.prio == 8'd0) ? 8'd0 : hold_q.prio - 8'd1;

	always_comb begin
		new_entry.id   = req.proc_id;
		new_entry.prio = req.priority_req;
		new_entry.need = (req.need_time == 8'd0) ? 8'd1 : req.need_time;
		new_entry.run  = 8'd0;

		requeue_entry.id   = hold_q.id;
		requeue_entry.prio = prio_dec;
		requeue_entry.need = hold_q.need;
		requeue_entry.run  = run_inc;
	end

	// chain command
	always_comb begin
		ctl.pop    = accept && (req.action == ACT_RUN) && !empty;
		ctl.insert = (accept && (req.action == ACT_ADD) && !full) ||
		             ((state_q == S_RUN) && out_free && !finish);
		ctl.ins    = (state_q == S_RUN) ? requeue_entry : new_entry;
	end

	// row of cells, each wired to its neighbors
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   occ;
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_ge    = 1'b1;
			assign left_entry = ctl.ins;
		end else begin : g_mid
			assign left_ge    = cell_ge[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		dps_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// control state, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCEPT;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ACCEPT: begin
					if (accept) begin
						out_q.ran_id       <= 8'd0;
						out_q.new_priority <= 8'd0;
						out_q.run_time     <= 8'd0;
						if (req.action == ACT_ADD) begin
							if (full) begin
								out_q.status      <= ST_FULL;
								out_q.queue_count <= ext_now[4:0];
							end else begin
								count_q           <= cnt_plus;
								out_q.status      <= ST_ADDED;
								out_q.queue_count <= ext_plus[4:0];
							end
						end else if (empty) begin
							out_q.status      <= ST_IDLE;
							out_q.queue_count <= ext_now[4:0];
						end else begin
							hold_q  <= cell_entry[0];
							count_q <= cnt_minus;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (out_free) begin
						out_q.ran_id   <= hold_q.id;
						out_q.run_time <= run_inc;
						state_q        <= S_ACCEPT;
						if (finish) begin
							out_q.status       <= ST_FINISHED;
							out_q.new_priority <= hold_q.prio;
							out_q.queue_count  <= ext_now[4:0];
						end else begin
							count_q            <= cnt_plus;
							out_q.status       <= ST_REQUEUED;
							out_q.new_priority <= prio_dec;
							out_q.queue_count  <= ext_plus[4:0];
						end
					end
				end
				default: begin
					state_q <= S_ACCEPT;
				end
			endcase
		end
	end

endmodule
